### src/multiturn_encoder_unwrap_rate_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn encoder unwrap unit
// Simulation-only checks; the bodies compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ENCODER_UNWRAP_RATE_AVERAGE_UNIT_ASSERT_SVH
`define MULTITURN_ENCODER_UNWRAP_RATE_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define MEURA_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: condition violated");

// Check that a trigger is followed by a condition in the next cycle
`define MEURA_ASSERT_NEXT(lbl, clk, rst, trig, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("assertion failed: next-cycle condition violated");

`else

`define MEURA_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define MEURA_ASSERT_NEXT(lbl, clk, rst, trig, expr)

`endif

`endif

### src/meura_pkg.sv
// ----------------------------------------------------------------------------
// meura_pkg
// Widths, constants and types shared by the encoder unwrap unit and its
// channel interfaces.
// ----------------------------------------------------------------------------
package meura_pkg;

   // Field widths
   localparam int RAW_W   = 13;
   localparam int DELTA_W = 14;
   localparam int TURN_W  = 24;
   localparam int CONT_W  = RAW_W + TURN_W;
   localparam int OFFS_W  = CONT_W + 1;
   localparam int ANGLE_W = 46;

   // Ring of recent deltas
   localparam int RING_DEPTH = 8;
   localparam int RING_SHIFT = $clog2(RING_DEPTH);
   localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W      = DELTA_W + RING_SHIFT;

   // Encoder geometry
   localparam int HALF_TURN = 4096;
   localparam int FULL_TURN = 8192;

   typedef logic        [RAW_W-1:0]   raw_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [TURN_W-1:0]  turn_type;
   typedef logic signed [CONT_W-1:0]  cont_type;
   typedef logic signed [OFFS_W-1:0]  offs_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [SLOT_W-1:0]  slot_type;

   localparam turn_type  TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
   localparam turn_type  TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
   localparam delta_type HALF_POS = delta_type'(HALF_TURN);
   localparam delta_type HALF_NEG = -delta_type'(HALF_TURN);
   localparam delta_type WRAP_ADJ = delta_type'(FULL_TURN);
   localparam slot_type  SLOT_LAST = slot_type'(RING_DEPTH - 1);
   localparam sum_type   SUM_ROUND = sum_type'(RING_DEPTH - 1);

endpackage

### src/meura_req_if.sv
// ----------------------------------------------------------------------------
// meura_req_if
// Input channel: one absolute encoder reading per transfer.
// ----------------------------------------------------------------------------
interface meura_req_if
   import meura_pkg::*;
   ();
   logic    valid;
   logic    ready;
   raw_type raw_position;

   modport source (output valid, output raw_position, input ready);
   modport sink   (input valid, input raw_position, output ready);
endinterface

### src/meura_rsp_if.sv
// ----------------------------------------------------------------------------
// meura_rsp_if
// Result channel: unwrapped delta, turns, position, angle and average rate.
// ----------------------------------------------------------------------------
interface meura_rsp_if
   import meura_pkg::*;
   ();
   logic      valid;
   logic      ready;
   delta_type step_delta;
   turn_type  turn_count;
   cont_type  continuous_position;
   angle_type angle_scaled;
   delta_type average_delta;

   modport source (output valid, output step_delta, output turn_count,
                   output continuous_position, output angle_scaled,
                   output average_delta, input ready);
   modport sink   (input valid, input step_delta, input turn_count,
                   input continuous_position, input angle_scaled,
                   input average_delta, output ready);
endinterface

### src/meura_csr_if.sv
// ----------------------------------------------------------------------------
// meura_csr_if
// Configuration write channel for the angle bias register.
// ----------------------------------------------------------------------------
interface meura_csr_if
   import meura_pkg::*;
   ();
   logic    valid;
   logic    ready;
   raw_type angle_bias;

   modport source (output valid, output angle_bias, input ready);
   modport sink   (input valid, input angle_bias, output ready);
endinterface

### src/multiturn_encoder_unwrap_rate_average_unit.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_unwrap_rate_average_unit
// Unwraps 13-bit absolute encoder readings into a multi-turn position, an
// angle in degrees times 8192 and a moving-average rate over the last deltas.
// ----------------------------------------------------------------------------
// Accepts one reading per clock while the result side does not stall, and
// returns one result per reading. Each reading passes through the stage 1,
// stage 2 and result registers before its result is presented. Full rate holds
// because the delta ring memory has one read and one write port: each item
// reads its slot in the accept cycle and writes it back when it leaves stage 1,
// with the write forwarded when the next item reads the same slot. The ring
// starts as all zero deltas through per-entry valid bits cleared by reset, so
// no clearing pass follows reset. The bias register is written through the csr
// channel, which is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module multiturn_encoder_unwrap_rate_average_unit
   import meura_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   meura_req_if.sink    req,
   meura_rsp_if.source  rsp,
   meura_csr_if.sink    csr
);

`include "multiturn_encoder_unwrap_rate_average_unit_assert.svh"

   // Control state
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   raw_type               prev_ff, prev_in;
   turn_type              turns_ff, turns_in;
   slot_type              slot_ff, slot_in;
   sum_type               sum_ff, sum_in;
   raw_type               bias_ff, bias_in;
   logic [RING_DEPTH-1:0] ring_valid_ff, ring_valid_in;

   // Payload registers
   raw_type   s1_reading_ff;
   delta_type s1_delta_ff;
   turn_type  s1_turns_ff;
   slot_type  s1_slot_ff;
   delta_type rd_data_ff;
   logic      rd_hit_ff;
   delta_type s2_delta_ff;
   turn_type  s2_turns_ff;
   cont_type  s2_cont_ff;
   offs_type  s2_offs_ff;
   delta_type rsp_delta_ff;
   turn_type  rsp_turns_ff;
   cont_type  rsp_cont_ff;
   angle_type rsp_angle_ff;
   delta_type rsp_avg_ff;

   // Delta ring memory
   delta_type ring_mem [RING_DEPTH];

   logic      advance;
   logic      req_fire;
   logic      ring_wr;
   logic      fwd_hit;
   delta_type diff;
   delta_type delta;
   turn_type  turns_next;
   delta_type old_delta;
   cont_type  cont;
   offs_type  offs;
   sum_type   sum_next;
   angle_type offs_ext;
   angle_type angle;
   sum_type   sum_biased;
   delta_type avg;

   // Whole pipeline moves when the result register is free or being taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign req_fire  = req.valid && advance;
   assign ring_wr   = s1_valid_ff && advance;
   assign fwd_hit   = ring_wr && (s1_slot_ff == slot_ff);
   assign csr.ready = 1'b1;

   // Stage 0: wrap-corrected delta and saturating turn count
   always_comb begin
      diff       = delta_type'({1'b0, req.raw_position}) - delta_type'({1'b0, prev_ff});
      delta      = diff;
      turns_next = turns_ff;
      if (diff < HALF_NEG) begin
         delta = diff + WRAP_ADJ;
         if (turns_ff != TURN_MAX) begin
            turns_next = turns_ff + turn_type'(1);
         end
      end else if (diff > HALF_POS) begin
         delta = diff - WRAP_ADJ;
         if (turns_ff != TURN_MIN) begin
            turns_next = turns_ff - turn_type'(1);
         end
      end
   end

   // Stage 1: position, bias offset and running ring sum
   always_comb begin
      old_delta = rd_hit_ff ? rd_data_ff : '0;
      cont      = {s1_turns_ff, s1_reading_ff};
      offs      = offs_type'(cont) - offs_type'({1'b0, bias_ff});
      sum_next  = sum_ff - sum_type'(old_delta) + sum_type'(s1_delta_ff);
   end

   // Stage 2: angle by shift-add (x360) and average truncated toward zero
   always_comb begin
      offs_ext   = angle_type'(s2_offs_ff);
      angle      = (offs_ext <<< 8) + (offs_ext <<< 6) + (offs_ext <<< 5)
                 + (offs_ext <<< 3);
      sum_biased = sum_ff[SUM_W-1] ? (sum_ff + SUM_ROUND) : sum_ff;
      avg        = delta_type'(sum_biased >>> RING_SHIFT);
   end

   // Next control state
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s2_valid_in   = s2_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      prev_in       = prev_ff;
      turns_in      = turns_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      bias_in       = bias_ff;
      ring_valid_in = ring_valid_ff;
      if (advance) begin
         s1_valid_in  = req.valid;
         s2_valid_in  = s1_valid_ff;
         rsp_valid_in = s2_valid_ff;
      end
      if (req_fire) begin
         prev_in  = req.raw_position;
         turns_in = turns_next;
         slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + slot_type'(1);
      end
      if (ring_wr) begin
         sum_in = sum_next;
         ring_valid_in[s1_slot_ff] = 1'b1;
      end
      if (csr.valid) begin
         bias_in = csr.angle_bias;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         turns_ff      <= '0;
         slot_ff       <= '0;
         sum_ff        <= '0;
         bias_ff       <= '0;
         ring_valid_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_ff       <= prev_in;
         turns_ff      <= turns_in;
         slot_ff       <= slot_in;
         sum_ff        <= sum_in;
         bias_ff       <= bias_in;
         ring_valid_ff <= ring_valid_in;
      end
   end

   // Ring memory: read at accept, write back from stage 1, forward same slot
   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[s1_slot_ff] <= s1_delta_ff;
      end
      if (req_fire) begin
         if (fwd_hit) begin
            rd_data_ff <= s1_delta_ff;
            rd_hit_ff  <= 1'b1;
         end else begin
            rd_data_ff <= ring_mem[slot_ff];
            rd_hit_ff  <= ring_valid_ff[slot_ff];
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_reading_ff <= req.raw_position;
         s1_delta_ff   <= delta;
         s1_turns_ff   <= turns_next;
         s1_slot_ff    <= slot_ff;
      end
      if (advance) begin
         s2_delta_ff  <= s1_delta_ff;
         s2_turns_ff  <= s1_turns_ff;
         s2_cont_ff   <= cont;
         s2_offs_ff   <= offs;
         rsp_delta_ff <= s2_delta_ff;
         rsp_turns_ff <= s2_turns_ff;
         rsp_cont_ff  <= s2_cont_ff;
         rsp_angle_ff <= angle;
         rsp_avg_ff   <= avg;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.step_delta          = rsp_delta_ff;
   assign rsp.turn_count          = rsp_turns_ff;
   assign rsp.continuous_position = rsp_cont_ff;
   assign rsp.angle_scaled        = rsp_angle_ff;
   assign rsp.average_delta       = rsp_avg_ff;

   // Turn count moves by at most one per transfer
   `MEURA_ASSERT_NEXT(a_turn_step, clock, reset, req_fire, ((turns_ff - $past(turns_ff)) == turn_type'(0)) || ((turns_ff - $past(turns_ff)) == turn_type'(1)) || ((turns_ff - $past(turns_ff)) == -turn_type'(1)))
   // Corrected delta stays within half a turn
   `MEURA_ASSERT_ALWAYS(a_delta_range, clock, reset, !s1_valid_ff || ((s1_delta_ff >= HALF_NEG) && (s1_delta_ff <= HALF_POS)))
   // Running sum stays within the ring's reach
   `MEURA_ASSERT_ALWAYS(a_sum_range, clock, reset, (sum_ff >= -sum_type'(RING_DEPTH * HALF_TURN)) && (sum_ff <= sum_type'(RING_DEPTH * HALF_TURN)))
   // An item leaving stage 2 lands in the result register
   `MEURA_ASSERT_NEXT(a_rsp_load, clock, reset, s2_valid_ff && advance, rsp_valid_ff)

endmodule
